FILE: src/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising edge while out of reset
`define ASSERT_AT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");

// property that must never hold while out of reset
`define ASSERT_NEVER(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(prop)) \
    else $error("forbidden condition seen");

`endif

FILE: src/ferl_pkg.sv
// types and constants of the fault event ring logger
`default_nettype none

package ferl_pkg;

  localparam int unsigned LOG_DEPTH          = 16;
  localparam int unsigned PTR_W              = $clog2(LOG_DEPTH);
  localparam int unsigned COUNT_W            = $clog2(LOG_DEPTH + 1);
  localparam logic [31:0] MIN_INTERVAL_RESET = 32'd1000;

  typedef enum logic [1:0] {
    MODE_LOG   = 2'd0,
    MODE_READ  = 2'd1,
    MODE_CLEAR = 2'd2
  } mode_e;

  typedef enum logic [2:0] {
    ST_LOGGED    = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_DEBOUNCED = 3'd2,
    ST_HIT       = 3'd3,
    ST_MISS      = 3'd4,
    ST_CLEARED   = 3'd5
  } status_e;

  typedef struct packed {
    mode_e       mode;
    logic [7:0]  error_code;
    logic [7:0]  fault_flags;
    logic [7:0]  subsystem;
    logic [7:0]  system_state;
    logic [31:0] uptime_ms;
    logic [7:0]  read_index;
  } req_t;

  typedef struct packed {
    status_e     status;
    logic [4:0]  entry_count;
    logic [7:0]  out_error_code;
    logic [7:0]  out_fault_flags;
    logic [7:0]  out_subsystem;
    logic [7:0]  out_system_state;
    logic [31:0] out_uptime_ms;
  } rsp_t;

endpackage

`default_nettype wire

FILE: src/fault_event_ring_logger_core.sv
// fault event ring logger: record ring with duplicate and debounce filtering
//
//   port group              direction  timing
//   start / req_i / busy    in / out   request taken when start && !busy
//   done_o / rsp_o          out        one-cycle strobe, cannot be held off
//   cfg_we_i / cfg_wdata_i  in         min interval written when cfg_we_i
//
// every request's result is registered and shows on the cycle after it is taken
// the ring is a 16 x 64 memory with one write or one registered read per request
// busy stays low, so a request can be taken in every cycle
// reset clears pointer, count and filter memory; ring contents are not cleared
`default_nettype none

module fault_event_ring_logger_core (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start,
  output logic                 busy,
  input  wire ferl_pkg::req_t  req_i,
  output logic                 done_o,
  output ferl_pkg::rsp_t       rsp_o,
  input  wire logic            cfg_we_i,
  input  wire logic [31:0]     cfg_wdata_i
);
  import ferl_pkg::*;

  typedef struct packed {
    logic [31:0] uptime_ms;
    logic [7:0]  system_state;
    logic [7:0]  subsystem;
    logic [7:0]  fault_flags;
    logic [7:0]  error_code;
  } record_t;

  record_t              mem_q [LOG_DEPTH];
  record_t              rd_q;
  logic [PTR_W-1:0]     wp_q, wp_d;
  logic [COUNT_W-1:0]   count_q, count_d;
  logic [7:0]           last_code_q, last_code_d;
  logic [7:0]           last_flags_q, last_flags_d;
  logic [31:0]          last_up_q, last_up_d;
  logic [31:0]          min_interval_q;
  status_e              status_q, status_d;
  logic                 done_q;

  logic                 accept;
  logic                 do_write;
  logic                 do_read;
  logic [PTR_W-1:0]     rd_addr;
  logic [31:0]          up_diff;
  record_t              wr_rec;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign up_diff = req_i.uptime_ms - last_up_q;
  assign rd_addr = PTR_W'(wp_q + req_i.read_index[PTR_W-1:0] - count_q[PTR_W-1:0]);
  assign wr_rec  = '{uptime_ms:    req_i.uptime_ms,
                     system_state: req_i.system_state,
                     subsystem:    req_i.subsystem,
                     fault_flags:  req_i.fault_flags,
                     error_code:   req_i.error_code};

  always_comb begin
    wp_d         = wp_q;
    count_d      = count_q;
    last_code_d  = last_code_q;
    last_flags_d = last_flags_q;
    last_up_d    = last_up_q;
    status_d     = ST_MISS;
    do_write     = 1'b0;
    do_read      = 1'b0;
    case (req_i.mode)
      MODE_LOG: begin
        if (req_i.error_code == last_code_q && req_i.fault_flags == last_flags_q) begin
          status_d = ST_DUPLICATE;
        end else if (req_i.error_code == last_code_q && last_up_q != 32'd0 &&
                     up_diff < min_interval_q) begin
          status_d = ST_DEBOUNCED;
        end else begin
          status_d     = ST_LOGGED;
          do_write     = 1'b1;
          wp_d         = PTR_W'(wp_q + 1'b1);
          if (count_q != COUNT_W'(LOG_DEPTH)) begin
            count_d = COUNT_W'(count_q + 1'b1);
          end
          last_code_d  = req_i.error_code;
          last_flags_d = req_i.fault_flags;
          last_up_d    = req_i.uptime_ms;
        end
      end
      MODE_READ: begin
        if (req_i.read_index < 8'(count_q)) begin
          status_d = ST_HIT;
          do_read  = 1'b1;
        end
      end
      MODE_CLEAR: begin
        status_d = ST_CLEARED;
        wp_d     = '0;
        count_d  = '0;
      end
      default: begin
        status_d = ST_MISS;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q           <= '0;
      count_q        <= '0;
      last_code_q    <= '0;
      last_flags_q   <= '0;
      last_up_q      <= '0;
      status_q       <= ST_MISS;
      done_q         <= 1'b0;
      min_interval_q <= MIN_INTERVAL_RESET;
    end else begin
      done_q <= accept;
      if (accept) begin
        wp_q         <= wp_d;
        count_q      <= count_d;
        last_code_q  <= last_code_d;
        last_flags_q <= last_flags_d;
        last_up_q    <= last_up_d;
        status_q     <= status_d;
      end
      if (cfg_we_i) begin
        min_interval_q <= cfg_wdata_i;
      end
    end
  end

  // ring memory: one write or one registered read per request
  always_ff @(posedge clk_i) begin
    if (accept && do_write) begin
      mem_q[wp_q] <= wr_rec;
    end
    if (accept && do_read) begin
      rd_q <= mem_q[rd_addr];
    end
  end

  always_comb begin
    rsp_o             = '0;
    rsp_o.status      = status_q;
    rsp_o.entry_count = 5'(count_q);
    if (status_q == ST_HIT) begin
      rsp_o.out_error_code   = rd_q.error_code;
      rsp_o.out_fault_flags  = rd_q.fault_flags;
      rsp_o.out_subsystem    = rd_q.subsystem;
      rsp_o.out_system_state = rd_q.system_state;
      rsp_o.out_uptime_ms    = rd_q.uptime_ms;
    end
  end

  assign done_o = done_q;

endmodule

`default_nettype wire

FILE: src/ferl_checker.sv
// port-level checks for the fault event ring logger
`default_nettype none

`include "assert_macros.svh"

module ferl_checker (
  input wire logic            clk_i,
  input wire logic            rst_ni,
  input wire logic            start,
  input wire logic            busy,
  input wire ferl_pkg::req_t  req_i,
  input wire logic            done_o,
  input wire ferl_pkg::rsp_t  rsp_o,
  input wire logic            cfg_we_i,
  input wire logic [31:0]     cfg_wdata_i
);
  import ferl_pkg::*;

  logic unused_cfg;
  logic rec_zero;
  assign unused_cfg = cfg_we_i ^ (^cfg_wdata_i) ^ (^req_i);
  assign rec_zero   = rsp_o.out_error_code == 8'd0 && rsp_o.out_fault_flags == 8'd0 &&
                      rsp_o.out_subsystem == 8'd0 && rsp_o.out_system_state == 8'd0 &&
                      rsp_o.out_uptime_ms == 32'd0;

  // one result for each request, on the next cycle
  `ASSERT_AT(a_done_follows, clk_i, rst_ni, rst_ni && start && !busy |=> done_o)
  `ASSERT_AT(a_no_spurious, clk_i, rst_ni, !(start && !busy) |=> !done_o)
  // record fields are zero unless the read hit
  `ASSERT_AT(a_zero_fields, clk_i, rst_ni, done_o && rsp_o.status != ST_HIT |-> rec_zero)
  `ASSERT_NEVER(a_count_range, clk_i, rst_ni, done_o && rsp_o.entry_count > 5'(LOG_DEPTH))
  `ASSERT_AT(a_clear_empty, clk_i, rst_ni, done_o && rsp_o.status == ST_CLEARED |-> rsp_o.entry_count == 5'd0)

endmodule

bind fault_event_ring_logger_core ferl_checker u_ferl_checker (.*);

`default_nettype wire
